[rtl/core/tlpt_pkg.sv]
// shared types and constants for the two-level page table engine
// no dependencies
package tlpt_pkg;

  localparam int DIR_ENTRIES   = 1024;
  localparam int TABLE_ENTRIES = 1024;
  localparam int TABLE_POOL_D  = 64;
  localparam int DIR_AW        = $clog2(DIR_ENTRIES);
  localparam int TE_AW         = $clog2(TABLE_ENTRIES);
  localparam int PAGE_SHIFT    = 12;
  localparam int FRAME_W       = 32 - PAGE_SHIFT;
  localparam logic [PAGE_SHIFT-1:0] OFFSET_MASK = 12'hFFF;

  // entry word: {present, writable, user, frame}
  localparam int ENT_W   = FRAME_W + 3;
  localparam int ENT_P   = ENT_W - 1;
  localparam int ENT_WR  = ENT_W - 2;
  localparam int ENT_US  = ENT_W - 3;
  localparam logic [ENT_W-1:0] ENT_RESET = {1'b0, 1'b1, 1'b0, {FRAME_W{1'b0}}};

  localparam logic [1:0] ACT_MAP   = 2'd0;
  localparam logic [1:0] ACT_UNMAP = 2'd1;
  localparam logic [1:0] ACT_XLATE = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOTMAP  = 2'd1;
  localparam logic [1:0] ST_NOTABLE = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_DIR   = 4'b0100,
    S_ENT   = 4'b1000
  } seq_state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
    logic        writable;
    logic        user;
  } result_t;

endpackage

[rtl/core/tlpt_ram.sv]
// generic single-port synchronous ram with registered read
// no dependencies
module tlpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/tlpt_seq.sv]
// sequencer: clearing pass, directory lookup, entry read-modify-write, result register
// depends on tlpt_pkg
module tlpt_seq import tlpt_pkg::*; #(
  parameter int TABLE_POOL = TABLE_POOL_D,
  parameter int SLOT_W     = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1,
  parameter int ENT_AW     = SLOT_W + TE_AW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        in_action,
  input  logic [31:0]       in_virt_addr,
  input  logic [31:0]       in_map_addr,
  input  logic [2:0]        in_map_flags,
  output logic              out_valid,
  input  logic              out_ready,
  output result_t           out_result,
  output logic              dir_we,
  output logic [DIR_AW-1:0] dir_addr,
  output logic [SLOT_W:0]   dir_wdata,
  input  logic [SLOT_W:0]   dir_rdata,
  output logic              ent_we,
  output logic [ENT_AW-1:0] ent_addr,
  output logic [ENT_W-1:0]  ent_wdata,
  input  logic [ENT_W-1:0]  ent_rdata
);

  localparam int CNT_W = $clog2(TABLE_POOL + 1);
  localparam int ENT_DEPTH = TABLE_POOL * TABLE_ENTRIES;
  localparam logic [ENT_AW-1:0] CLR_LAST = ENT_AW'(ENT_DEPTH - 1);
  localparam logic [CNT_W-1:0]  POOL_CNT = CNT_W'(TABLE_POOL);

  seq_state_t state_r, state_nxt;
  logic [ENT_AW-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [ENT_AW-1:0] ent_addr_r, ent_addr_nxt;
  logic [1:0] act_r;
  logic [31:0] va_r;
  logic [FRAME_W-1:0] frame_r;
  logic [2:0] flags_r;
  logic out_valid_r, out_valid_nxt;
  result_t res_r, res_nxt;

  logic out_free;
  logic dir_hit;
  logic [SLOT_W-1:0] dir_slot, map_slot;
  logic [TE_AW-1:0] te_idx;

  assign out_free  = !out_valid_r || out_ready;
  assign dir_hit   = dir_rdata[SLOT_W];
  assign dir_slot  = dir_rdata[SLOT_W-1:0];
  assign map_slot  = dir_hit ? dir_slot : used_r[SLOT_W-1:0];
  assign te_idx    = va_r[PAGE_SHIFT +: TE_AW];
  assign in_tready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_result = res_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    used_nxt      = used_r;
    ent_addr_nxt  = ent_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    dir_we        = 1'b0;
    dir_addr      = va_r[31 -: DIR_AW];
    dir_wdata     = {1'b1, map_slot};
    ent_we        = 1'b0;
    ent_addr      = ent_addr_r;
    ent_wdata     = {flags_r[0], flags_r[1], flags_r[2], frame_r};
    case (state_r)
      S_CLEAR: begin
        dir_we    = (clr_r < ENT_AW'(DIR_ENTRIES));
        dir_addr  = clr_r[DIR_AW-1:0];
        dir_wdata = '0;
        ent_we    = 1'b1;
        ent_addr  = clr_r;
        ent_wdata = ENT_RESET;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        dir_addr = in_virt_addr[31 -: DIR_AW];
        if (in_tvalid) begin
          state_nxt = S_DIR;
        end
      end
      S_DIR: begin
        ent_addr = {map_slot, te_idx};
        if (out_free) begin
          res_nxt = '{status: ST_DONE, addr: '0, writable: 1'b0, user: 1'b0};
          case (act_r)
            ACT_MAP: begin
              if (!dir_hit && used_r == POOL_CNT) begin
                res_nxt.status = ST_NOTABLE;
              end else begin
                dir_we = !dir_hit;
                ent_we = 1'b1;
                if (!dir_hit) begin
                  used_nxt = used_r + 1'b1;
                end
              end
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
            ACT_UNMAP, ACT_XLATE: begin
              if (!dir_hit) begin
                res_nxt.status = ST_NOTMAP;
                out_valid_nxt  = 1'b1;
                state_nxt      = S_IDLE;
              end else begin
                ent_addr_nxt = {dir_slot, te_idx};
                state_nxt    = S_ENT;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          endcase
        end
      end
      S_ENT: begin
        ent_wdata = ent_rdata;
        ent_wdata[ENT_P] = 1'b0;
        if (out_free) begin
          res_nxt = '{status: ST_DONE, addr: '0, writable: 1'b0, user: 1'b0};
          if (!ent_rdata[ENT_P]) begin
            res_nxt.status = ST_NOTMAP;
          end else if (act_r == ACT_XLATE) begin
            res_nxt.addr     = {ent_rdata[FRAME_W-1:0], va_r[PAGE_SHIFT-1:0] & OFFSET_MASK};
            res_nxt.writable = ent_rdata[ENT_WR];
            res_nxt.user     = ent_rdata[ENT_US];
          end
          ent_we        = (act_r == ACT_UNMAP);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_addr_r <= ent_addr_nxt;
    res_r      <= res_nxt;
    if (in_tvalid && in_tready) begin
      act_r   <= in_action;
      va_r    <= in_virt_addr;
      frame_r <= in_map_addr[31 -: FRAME_W];
      flags_r <= in_map_flags;
    end
  end

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= POOL_CNT) else $error("table count beyond pool");

  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIR && dir_we) |=> used_r == $past(used_r) + 1'b1)
    else $error("directory allocation without count step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && res_r == $past(res_r)))
    else $error("pending result overwritten");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (!in_tready && !out_valid_r))
    else $error("transaction during clearing pass");

  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIR || state_r == S_ENT) && (dir_we || ent_we)) |-> out_free)
    else $error("memory write while result stalled");

endmodule

[rtl/core/two_level_page_table_engine.sv]
// top level of the two-level page table engine
// depends on tlpt_pkg, tlpt_ram, tlpt_seq
//
//  channel | ports  | tuser          | tdata (lsb first)
//  input   | in_*   | action[1:0]    | virt_addr[31:0] map_addr[63:32] map_flags[66:64]
//  output  | out_*  | status[1:0]    | translated_addr[31:0] page_writable[32] user_bit[33]
//
// one transaction at a time: map ends in the directory step, unmap and translate
// go on to an entry step (not when the directory entry is absent), as set by the
// directory read followed by the dependent entry read, each a registered ram read
// after reset a clearing pass over all TABLE_POOL*1024 entry addresses initializes
// both rams, in_tready stays low meanwhile
// a result waits in the output register; a following item is accepted but stalls
// in its directory step until that result is taken
module two_level_page_table_engine import tlpt_pkg::*; #(
  parameter int TABLE_POOL = TABLE_POOL_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // virt_addr, map_addr, map_flags, zero pad
  input  logic [1:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // translated_addr, page_writable, user_bit, zero pad
  output logic [1:0]  out_tuser   // status
);

  localparam int SLOT_W    = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
  localparam int ENT_AW    = SLOT_W + TE_AW;
  localparam int ENT_DEPTH = TABLE_POOL * TABLE_ENTRIES;

  logic              dir_we, ent_we;
  logic [DIR_AW-1:0] dir_addr;
  logic [SLOT_W:0]   dir_wdata, dir_rdata;
  logic [ENT_AW-1:0] ent_addr;
  logic [ENT_W-1:0]  ent_wdata, ent_rdata;
  result_t           result;

  tlpt_seq #(
    .TABLE_POOL (TABLE_POOL),
    .SLOT_W     (SLOT_W),
    .ENT_AW     (ENT_AW)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_action    (in_tuser),
    .in_virt_addr (in_tdata[31:0]),
    .in_map_addr  (in_tdata[63:32]),
    .in_map_flags (in_tdata[66:64]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_result   (result),
    .dir_we       (dir_we),
    .dir_addr     (dir_addr),
    .dir_wdata    (dir_wdata),
    .dir_rdata    (dir_rdata),
    .ent_we       (ent_we),
    .ent_addr     (ent_addr),
    .ent_wdata    (ent_wdata),
    .ent_rdata    (ent_rdata)
  );

  tlpt_ram #(
    .WIDTH (SLOT_W + 1),
    .DEPTH (DIR_ENTRIES),
    .AW    (DIR_AW)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .addr  (dir_addr),
    .wdata (dir_wdata),
    .rdata (dir_rdata)
  );

  tlpt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENT_DEPTH),
    .AW    (ENT_AW)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .addr  (ent_addr),
    .wdata (ent_wdata),
    .rdata (ent_rdata)
  );

  assign out_tuser = result.status;
  assign out_tdata = {6'b0, result.user, result.writable, result.addr};

endmodule
